[design/mxeu_pkg.sv]
// Package for the 64-bit integer execute unit: operation codes, item types
// and the classified command passed from the decode front to the execute back.
package mxeu_pkg;

  localparam int unsigned KindW = 7;
  localparam int unsigned DataW = 64;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [KindW-1:0] {
    OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWL, OP_LWR, OP_SB, OP_SH, OP_SW,
    OP_SWL, OP_SWR, OP_LD, OP_LDL, OP_LDR, OP_LL, OP_LLD, OP_LWU, OP_SC,
    OP_SCD, OP_SD, OP_SDL, OP_SDR,
    OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
    OP_DADDI, OP_DADDIU, OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_SLT, OP_SLTU,
    OP_AND, OP_OR, OP_XOR, OP_NOR, OP_DADD, OP_DADDU, OP_DSUB, OP_DSUBU,
    OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_DSLL, OP_DSRL,
    OP_DSRA, OP_DSLLV, OP_DSRLV, OP_DSRAV, OP_DSLL32, OP_DSRL32, OP_DSRA32,
    OP_MULT, OP_MULTU, OP_DIV, OP_DIVU, OP_MFHI, OP_MFLO, OP_MTHI, OP_MTLO,
    OP_DMULT, OP_DMULTU, OP_DDIV, OP_DDIVU,
    OP_J, OP_JAL, OP_JR, OP_JALR, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_BLTZ,
    OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL,
    OP_BLTZL, OP_BGEZL, OP_BLTZALL, OP_BGEZALL,
    OP_SYNC, OP_SYSCALL, OP_BREAK, OP_TGE, OP_TGEU, OP_TLT, OP_TLTU, OP_TEQ,
    OP_TNE, OP_TGEI, OP_TGEIU, OP_TLTI, OP_TLTIU, OP_TEQI, OP_TNEI,
    OP_LWCZ, OP_SWCZ, OP_MTCZ, OP_MFCZ, OP_CTCZ, OP_CFCZ, OP_COPZ, OP_BCZT,
    OP_BCZF, OP_DMTCZ, OP_DMFCZ, OP_LDCZ, OP_SDCZ, OP_BCZTL, OP_BCZFL,
    OP_MTC0, OP_MFC0, OP_DMTC0, OP_DMFC0
  } op_e;

  // Unit class chosen by the front.
  typedef enum logic [1:0] {
    CLS_SIMPLE, CLS_MUL, CLS_DIV
  } cls_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [63:0]      source_value;
    logic [63:0]      second_value;
    logic [15:0]      immediate_field;
    logic [4:0]       shift_amount;
    logic [25:0]      jump_target;
    logic [63:0]      program_counter;
    logic [63:0]      coprocessor_value;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [63:0] memory_address;
    logic [63:0] next_counter;
    logic        redirect;
    logic        annul_slot;
    logic        trap_taken;
  } out_word_t;

  // Classified command in the queue.
  typedef struct packed {
    in_word_t    w;
    cls_e        cls;
    logic        is_signed;
    logic        is_word;
    logic [63:0] op_a;   // operand prepared for mul/div (extended for word ops)
    logic [63:0] op_b;
  } cmd_t;

  function automatic logic [63:0] sx32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

[design/mxeu_if.sv]
// Valid/ready channel interface carrying one word of a given type.
// Uses mxeu_pkg types through the parameter only.
interface mxeu_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/mxeu_front.sv]
// Decode front: accepts input words, classifies them and fills a small queue.
// Depends on mxeu_pkg.
module mxeu_front #(
  parameter int unsigned Depth = mxeu_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mxeu_pkg::in_word_t in_data_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output mxeu_pkg::cmd_t  cmd_o
);
  import mxeu_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;
  cmd_t            cls_c;
  logic            push, pop;
  op_e             op;

  always_comb begin
    op = op_e'(in_data_i.kind);
    cls_c = '0;
    cls_c.w = in_data_i;
    cls_c.cls = CLS_SIMPLE;
    cls_c.is_signed = 1'b0;
    cls_c.is_word = 1'b0;
    cls_c.op_a = in_data_i.source_value;
    cls_c.op_b = in_data_i.second_value;
    case (op)
      OP_MULT: begin
        cls_c.cls = CLS_MUL; cls_c.is_signed = 1'b1; cls_c.is_word = 1'b1;
        cls_c.op_a = sx32(in_data_i.source_value);
        cls_c.op_b = sx32(in_data_i.second_value);
      end
      OP_MULTU: begin
        cls_c.cls = CLS_MUL; cls_c.is_word = 1'b1;
        cls_c.op_a = {32'd0, in_data_i.source_value[31:0]};
        cls_c.op_b = {32'd0, in_data_i.second_value[31:0]};
      end
      OP_DMULT: begin
        cls_c.cls = CLS_MUL; cls_c.is_signed = 1'b1;
      end
      OP_DMULTU: cls_c.cls = CLS_MUL;
      OP_DIV: begin
        cls_c.cls = CLS_DIV; cls_c.is_signed = 1'b1; cls_c.is_word = 1'b1;
        cls_c.op_a = sx32(in_data_i.source_value);
        cls_c.op_b = sx32(in_data_i.second_value);
      end
      OP_DIVU: begin
        cls_c.cls = CLS_DIV; cls_c.is_word = 1'b1;
        cls_c.op_a = {32'd0, in_data_i.source_value[31:0]};
        cls_c.op_b = {32'd0, in_data_i.second_value[31:0]};
      end
      OP_DDIV: begin
        cls_c.cls = CLS_DIV; cls_c.is_signed = 1'b1;
      end
      OP_DDIVU: cls_c.cls = CLS_DIV;
      default: ;
    endcase
  end

  assign in_ready_o  = (cnt_q != (AW+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls_c;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

[design/mxeu_muldiv.sv]
// Shared multiply/divide unit: one bit of a 64-bit radix-2 shift-add multiply
// or restoring divide per cycle on magnitudes. Depends on mxeu_pkg.
module mxeu_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_div_i,
  input  logic        is_signed_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] lo_o,
  output logic [63:0] hi_o
);
  import mxeu_pkg::*;

  typedef enum logic [1:0] { ST_IDLE, ST_RUN, ST_FIX, ST_DONE } state_e;

  state_e        state_q;
  logic [6:0]    step_q;
  logic          div_q, neg_q, negr_q;
  logic [63:0]   mb_q;     // magnitude of second operand
  logic [127:0]  acc_q;    // mul: {hi,lo} product; div: {rem,quot}
  logic [63:0]   lo_q, hi_q;
  logic [63:0]   ma, mb;
  logic [64:0]   trial;
  logic [64:0]   msum;
  logic [127:0]  fix_prod;

  assign ma = (is_signed_i && a_i[63]) ? (64'd0 - a_i) : a_i;
  assign mb = (is_signed_i && b_i[63]) ? (64'd0 - b_i) : b_i;
  assign msum  = {1'b0, acc_q[127:64]} + (acc_q[0] ? {1'b0, mb_q} : 65'd0);
  assign trial = {acc_q[127:64], acc_q[63]} - {1'b0, mb_q};
  assign fix_prod = 128'd0 - acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_RUN;
            step_q <= '0;
          end
        end
        ST_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == 7'd63) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: state_q <= ST_DONE;
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          div_q <= is_div_i;
          neg_q <= is_signed_i && (a_i[63] ^ b_i[63]);
          negr_q <= is_signed_i && a_i[63];
          mb_q <= mb;
          acc_q <= {64'd0, ma};
        end
      end
      ST_RUN: begin
        if (div_q) begin
          // Shift one dividend bit into the remainder, subtract if it fits.
          if (!trial[64]) begin
            acc_q <= {trial[63:0], acc_q[62:0], 1'b1};
          end else begin
            acc_q <= {acc_q[126:0], 1'b0};
          end
        end else begin
          acc_q <= {msum, acc_q[63:1]};
        end
      end
      ST_FIX: begin
        if (div_q) begin
          lo_q <= neg_q ? (64'd0 - acc_q[63:0]) : acc_q[63:0];
          hi_q <= negr_q ? (64'd0 - acc_q[127:64]) : acc_q[127:64];
        end else begin
          lo_q <= neg_q ? fix_prod[63:0] : acc_q[63:0];
          hi_q <= neg_q ? fix_prod[127:64] : acc_q[127:64];
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == ST_DONE);
  assign lo_o = lo_q;
  assign hi_o = hi_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == 7'd63) |=> state_q == ST_FIX)
    else $error("iteration count slip");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_fix_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIX |=> done_o) else $error("missing done");

endmodule

[design/mxeu_back.sv]
// Execute back: ALU, branch/trap logic, HI/LO and the output register.
// Depends on mxeu_pkg and mxeu_muldiv.
module mxeu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  mxeu_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mxeu_pkg::out_word_t out_data_o
);
  import mxeu_pkg::*;

  typedef enum logic [1:0] { ST_READY, ST_WAIT } state_e;

  state_e      state_q;
  logic [63:0] hi_q, lo_q;
  logic        ov_q;
  out_word_t   od_q;
  out_word_t   res_c;
  logic        slot_free, take, md_start, md_done, hilo_we;
  logic [63:0] md_lo, md_hi, hilo_hi, hilo_lo;
  logic        is_div, div_zero, ddiv_ovf;
  logic [63:0] zero_hi;

  op_e         op;
  logic [63:0] rs, rt, simm, imm, pcv, cp, link, btgt;
  logic [5:0]  samt;
  logic [63:0] shl, shr, sar;
  logic [63:0] sh_src;
  logic [31:0] rt32;
  logic        lt_s_rt, lt_u_rt, lt_s_im, lt_u_im, cond, is_br, likely, lnk;

  assign slot_free = !ov_q || out_ready_i;
  assign is_div = (cmd_i.cls == CLS_DIV);
  assign div_zero = cmd_i.is_word ? (cmd_i.w.second_value[31:0] == 32'd0)
                                  : (cmd_i.w.second_value == 64'd0);
  assign ddiv_ovf = !cmd_i.is_word && cmd_i.is_signed &&
                    (cmd_i.w.source_value == 64'h8000_0000_0000_0000) &&
                    (cmd_i.w.second_value == '1);
  assign zero_hi = cmd_i.is_word ? sx32(cmd_i.w.source_value) : cmd_i.w.source_value;
  // Special divides finish without the iterative unit.
  assign md_start = cmd_valid_i && state_q == ST_READY && slot_free &&
                    cmd_i.cls != CLS_SIMPLE && !(is_div && (div_zero || ddiv_ovf));
  assign take = cmd_valid_i && slot_free &&
                ((state_q == ST_READY && !md_start) || (state_q == ST_WAIT && md_done));
  assign cmd_ready_o = take;

  mxeu_muldiv u_md (
    .clk_i, .rst_ni,
    .start_i(md_start), .is_div_i(is_div), .is_signed_i(cmd_i.is_signed),
    .a_i(cmd_i.op_a), .b_i(cmd_i.op_b),
    .done_o(md_done), .lo_o(md_lo), .hi_o(md_hi)
  );

  always_comb begin
    op = op_e'(cmd_i.w.kind);
    rs = cmd_i.w.source_value;
    rt = cmd_i.w.second_value;
    imm = {48'd0, cmd_i.w.immediate_field};
    simm = {{48{cmd_i.w.immediate_field[15]}}, cmd_i.w.immediate_field};
    pcv = cmd_i.w.program_counter;
    cp = cmd_i.w.coprocessor_value;
    link = pcv + 64'd4;
    btgt = pcv + {simm[61:0], 2'b00};
    rt32 = rt[31:0];
    lt_s_rt = $signed(rs) < $signed(rt);
    lt_u_rt = rs < rt;
    lt_s_im = $signed(rs) < $signed(simm);
    lt_u_im = rs < simm;
    // One shared shifter: amount and source picked per op.
    samt = {1'b0, cmd_i.w.shift_amount};
    sh_src = rt;
    case (op)
      OP_SLL, OP_SRL: sh_src = {32'd0, rt32};
      OP_SRA: sh_src = sx32(rt);
      OP_SLLV, OP_SRLV: begin sh_src = {32'd0, rt32}; samt = {1'b0, rs[4:0]}; end
      OP_SRAV: begin sh_src = sx32(rt); samt = {1'b0, rs[4:0]}; end
      OP_DSLLV, OP_DSRLV, OP_DSRAV: samt = rs[5:0];
      OP_DSLL32, OP_DSRL32, OP_DSRA32: samt = {1'b1, cmd_i.w.shift_amount};
      default: ;
    endcase
    shl = sh_src << samt;
    shr = sh_src >> samt;
    sar = 64'($signed(sh_src) >>> samt);

    res_c = '0;
    cond = 1'b0;
    is_br = 1'b0;
    likely = 1'b0;
    lnk = 1'b0;
    hilo_we = 1'b0;
    hilo_hi = hi_q;
    hilo_lo = lo_q;
    case (op)
      OP_ADDI, OP_ADDIU: res_c.result_value = sx32(rs + simm);
      OP_SLTI: res_c.result_value = {63'd0, lt_s_im};
      OP_SLTIU: res_c.result_value = {63'd0, lt_u_im};
      OP_ANDI: res_c.result_value = rs & imm;
      OP_ORI: res_c.result_value = rs | imm;
      OP_XORI: res_c.result_value = rs ^ imm;
      OP_LUI: res_c.result_value = sx32({32'd0, cmd_i.w.immediate_field, 16'd0});
      OP_DADDI, OP_DADDIU: res_c.result_value = rs + simm;
      OP_ADD, OP_ADDU: res_c.result_value = sx32(rs + rt);
      OP_SUB, OP_SUBU: res_c.result_value = sx32(rs - rt);
      OP_SLT: res_c.result_value = {63'd0, lt_s_rt};
      OP_SLTU: res_c.result_value = {63'd0, lt_u_rt};
      OP_AND: res_c.result_value = rs & rt;
      OP_OR: res_c.result_value = rs | rt;
      OP_XOR: res_c.result_value = rs ^ rt;
      OP_NOR: res_c.result_value = ~(rs | rt);
      OP_DADD, OP_DADDU: res_c.result_value = rs + rt;
      OP_DSUB, OP_DSUBU: res_c.result_value = rs - rt;
      OP_SLL, OP_SLLV: res_c.result_value = sx32(shl);
      OP_SRL, OP_SRLV: res_c.result_value = sx32(shr);
      OP_SRA, OP_SRAV: res_c.result_value = sx32(sar);
      OP_DSLL, OP_DSLLV, OP_DSLL32: res_c.result_value = shl;
      OP_DSRL, OP_DSRLV, OP_DSRL32: res_c.result_value = shr;
      OP_DSRA, OP_DSRAV, OP_DSRA32: res_c.result_value = sar;
      OP_MULT, OP_MULTU: begin
        hilo_we = 1'b1;
        hilo_lo = sx32(md_lo);
        hilo_hi = sx32({32'd0, md_lo[63:32]});
      end
      OP_DMULT, OP_DMULTU: begin
        hilo_we = 1'b1; hilo_lo = md_lo; hilo_hi = md_hi;
      end
      OP_DIV, OP_DIVU, OP_DDIV, OP_DDIVU: begin
        hilo_we = 1'b1;
        if (div_zero) begin
          hilo_lo = '1; hilo_hi = zero_hi;
        end else if (ddiv_ovf) begin
          hilo_lo = 64'h8000_0000_0000_0000; hilo_hi = '0;
        end else if (cmd_i.is_word) begin
          hilo_lo = sx32(md_lo); hilo_hi = sx32(md_hi);
        end else begin
          hilo_lo = md_lo; hilo_hi = md_hi;
        end
      end
      OP_MFHI: res_c.result_value = hi_q;
      OP_MFLO: res_c.result_value = lo_q;
      OP_MTHI: begin hilo_we = 1'b1; hilo_hi = rs; end
      OP_MTLO: begin hilo_we = 1'b1; hilo_lo = rs; end
      OP_J, OP_JAL: begin
        if (op == OP_JAL) res_c.result_value = link;
        res_c.next_counter = {pcv[63:28], cmd_i.w.jump_target, 2'b00};
        res_c.redirect = 1'b1;
      end
      OP_JR, OP_JALR: begin
        if (op == OP_JALR) res_c.result_value = link;
        res_c.next_counter = rs;
        res_c.redirect = 1'b1;
      end
      OP_BEQ, OP_BEQL: begin is_br = 1'b1; cond = rs == rt; likely = op == OP_BEQL; end
      OP_BNE, OP_BNEL: begin is_br = 1'b1; cond = rs != rt; likely = op == OP_BNEL; end
      OP_BLEZ, OP_BLEZL: begin
        is_br = 1'b1; cond = rs[63] || rs == 64'd0; likely = op == OP_BLEZL;
      end
      OP_BGTZ, OP_BGTZL: begin
        is_br = 1'b1; cond = !rs[63] && rs != 64'd0; likely = op == OP_BGTZL;
      end
      OP_BLTZ, OP_BLTZL: begin is_br = 1'b1; cond = rs[63]; likely = op == OP_BLTZL; end
      OP_BGEZ, OP_BGEZL: begin is_br = 1'b1; cond = !rs[63]; likely = op == OP_BGEZL; end
      OP_BLTZAL, OP_BLTZALL: begin
        is_br = 1'b1; lnk = 1'b1; cond = rs[63]; likely = op == OP_BLTZALL;
      end
      OP_BGEZAL, OP_BGEZALL: begin
        is_br = 1'b1; lnk = 1'b1; cond = !rs[63]; likely = op == OP_BGEZALL;
      end
      OP_TGE: res_c.trap_taken = !lt_s_rt;
      OP_TGEU: res_c.trap_taken = !lt_u_rt;
      OP_TLT: res_c.trap_taken = lt_s_rt;
      OP_TLTU: res_c.trap_taken = lt_u_rt;
      OP_TEQ: res_c.trap_taken = rs == rt;
      OP_TNE: res_c.trap_taken = rs != rt;
      OP_TGEI: res_c.trap_taken = !lt_s_im;
      OP_TGEIU: res_c.trap_taken = !lt_u_im;
      OP_TLTI: res_c.trap_taken = lt_s_im;
      OP_TLTIU: res_c.trap_taken = lt_u_im;
      OP_TEQI: res_c.trap_taken = rs == simm;
      OP_TNEI: res_c.trap_taken = rs != simm;
      OP_LWCZ, OP_SWCZ, OP_LDCZ, OP_SDCZ: begin
        res_c.result_value = rs + simm;
        res_c.memory_address = rs + simm;
      end
      OP_MTCZ, OP_MTC0: res_c.result_value = {32'd0, rt32};
      OP_MFCZ: res_c.result_value = {32'd0, cp[31:0]};
      OP_MFC0: res_c.result_value = sx32(cp);
      OP_DMTCZ, OP_DMTC0: res_c.result_value = rt;
      OP_DMFCZ, OP_DMFC0: res_c.result_value = cp;
      default: begin
        if (cmd_i.w.kind <= KindW'(OP_SDR)) res_c.memory_address = rs + simm;
      end
    endcase
    if (is_br) begin
      if (lnk) res_c.result_value = link;
      if (cond) begin
        res_c.redirect = 1'b1;
        res_c.next_counter = btgt;
      end else begin
        res_c.annul_slot = likely;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
      ov_q <= 1'b0;
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      case (state_q)
        ST_READY: if (md_start) state_q <= ST_WAIT;
        ST_WAIT: if (take) state_q <= ST_READY;
        default: state_q <= ST_READY;
      endcase
      if (take) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (take && hilo_we) begin
        hi_q <= hilo_hi;
        lo_q <= hilo_lo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) od_q <= res_c;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q && $stable(od_q)) else $error("output lost");
  a_wait_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && take) |-> md_done) else $error("early retire");
  a_no_start_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_start |-> state_q == ST_READY) else $error("start while busy");

endmodule

[design/mips64_integer_execute_unit.sv]
// Top level of the 64-bit integer execute unit.
// Depends on mxeu_pkg, mxeu_if, mxeu_front, mxeu_back and mxeu_muldiv.
//
// Use:
//   in_if  (sink)   : one decoded instruction word per handshake
//                     (valid && ready at a rising edge).
//   out_if (source) : one result word per instruction, in order.
// Simple ops (ALU, shift, branch, trap, move, HI/LO move, and
//   divides by zero or the doubleword signed overflow case) pass the decode
//   queue and then the output register before out_if valid rises; when
//   neither the receiver nor a multiply or divide stalls, the unit takes
//   one word per cycle.
// Multiplies and the remaining divides run on one shared radix-2 unit, one bit
//   per cycle, through start, one step per magnitude bit, sign fix and done;
//   meanwhile the back end holds and the queue fills, then in_if ready drops.
// Reset (rst_ni low, asynchronous) empties the queue, drops the output
//   valid and clears HI and LO to zero.
// When the receiver stalls, the result word holds in the output register,
//   the back end stops, and the queue of QueueDepth words takes new input
//   until full.
module mips64_integer_execute_unit #(
  parameter int unsigned QueueDepth = mxeu_pkg::QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  mxeu_if.sink   in_if,
  mxeu_if.source out_if
);
  import mxeu_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Front: classify and queue.
  mxeu_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // Back: execute, hold HI/LO, register the result.
  mxeu_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );

endmodule

[tb/sv/testbench.sv]
// Testbench for the 64-bit integer execute unit: drives decoded instruction
// words through mxeu_if and checks every result word against a predictor.
// Depends on mxeu_pkg, mxeu_if and the mips64_integer_execute_unit RTL.
module testbench;
  import mxeu_pkg::*;

  logic clk_i;
  logic rst_ni;

  mxeu_if #(.word_t(in_word_t))  in_if ();
  mxeu_if #(.word_t(out_word_t)) out_if ();

  mips64_integer_execute_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // HI/LO shadow registers of the predictor.
  logic [63:0] hi_q;
  logic [63:0] lo_q;

  out_word_t expected_q[$];
  int        n_errors;
  int        n_checked;
  int        n_sent;
  bit        quiet_mode;   // no idling on either side
  int        hold_cycles;  // receiver hold-off requested by a test
  bit        kind_seen[128];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // End the run if something hangs.
  initial begin
    #20_000_000;
    $display("** mips64_integer_execute_unit: FAILED **");
    $finish;
  end

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Compute the result of one instruction and update HI/LO.
  function automatic out_word_t exec_instr(input in_word_t w);
    out_word_t   o;
    logic [63:0] rs, rt, simm, imm, link, bt;
    logic [127:0] prod;
    logic [63:0] a, b;
    int          cond;
    bit          likely;
    op_e         op;
    rs = w.source_value;
    rt = w.second_value;
    imm = {48'd0, w.immediate_field};
    simm = sext16(w.immediate_field);
    link = w.program_counter + 64'd4;
    bt = w.program_counter + (simm << 2);
    o = '0;
    cond = -1;
    likely = 1'b0;
    op = op_e'(w.kind);
    case (op)
      OP_ADDI, OP_ADDIU: o.result_value = sext32(rs + simm);
      OP_SLTI: o.result_value = {63'd0, $signed(rs) < $signed(simm)};
      OP_SLTIU: o.result_value = {63'd0, rs < simm};
      OP_ANDI: o.result_value = rs & imm;
      OP_ORI: o.result_value = rs | imm;
      OP_XORI: o.result_value = rs ^ imm;
      OP_LUI: o.result_value = sext32(imm << 16);
      OP_DADDI, OP_DADDIU: o.result_value = rs + simm;
      OP_ADD, OP_ADDU: o.result_value = sext32(rs + rt);
      OP_SUB, OP_SUBU: o.result_value = sext32(rs - rt);
      OP_SLT: o.result_value = {63'd0, $signed(rs) < $signed(rt)};
      OP_SLTU: o.result_value = {63'd0, rs < rt};
      OP_AND: o.result_value = rs & rt;
      OP_OR: o.result_value = rs | rt;
      OP_XOR: o.result_value = rs ^ rt;
      OP_NOR: o.result_value = ~(rs | rt);
      OP_DADD, OP_DADDU: o.result_value = rs + rt;
      OP_DSUB, OP_DSUBU: o.result_value = rs - rt;
      OP_SLL: o.result_value = sext32(rt << w.shift_amount);
      OP_SRL: o.result_value = sext32({32'd0, rt[31:0]} >> w.shift_amount);
      OP_SRA: o.result_value = sext32($signed(sext32(rt)) >>> w.shift_amount);
      OP_SLLV: o.result_value = sext32(rt << rs[4:0]);
      OP_SRLV: o.result_value = sext32({32'd0, rt[31:0]} >> rs[4:0]);
      OP_SRAV: o.result_value = sext32($signed(sext32(rt)) >>> rs[4:0]);
      OP_DSLL: o.result_value = rt << w.shift_amount;
      OP_DSRL: o.result_value = rt >> w.shift_amount;
      OP_DSRA: o.result_value = $signed(rt) >>> w.shift_amount;
      OP_DSLLV: o.result_value = rt << rs[5:0];
      OP_DSRLV: o.result_value = rt >> rs[5:0];
      OP_DSRAV: o.result_value = $signed(rt) >>> rs[5:0];
      OP_DSLL32: o.result_value = rt << (7'd32 + w.shift_amount);
      OP_DSRL32: o.result_value = rt >> (7'd32 + w.shift_amount);
      OP_DSRA32: o.result_value = $signed(rt) >>> (7'd32 + w.shift_amount);
      OP_MULT, OP_MULTU: begin
        if (op == OP_MULT) a = sext32(rs) * sext32(rt);
        else a = {32'd0, rs[31:0]} * {32'd0, rt[31:0]};
        lo_q = sext32(a);
        hi_q = sext32(a >> 32);
      end
      OP_DIV: begin
        if (rt[31:0] == 32'd0) begin
          lo_q = '1;
          hi_q = sext32(rs);
        end else begin
          // 64-bit signed divide of the extended halves; never overflows
          a = sext32(rs);
          b = sext32(rt);
          lo_q = sext32($signed(a) / $signed(b));
          hi_q = sext32($signed(a) % $signed(b));
        end
      end
      OP_DIVU: begin
        if (rt[31:0] == 32'd0) begin
          lo_q = '1;
          hi_q = sext32(rs);
        end else begin
          lo_q = sext32({32'd0, rs[31:0]} / {32'd0, rt[31:0]});
          hi_q = sext32({32'd0, rs[31:0]} % {32'd0, rt[31:0]});
        end
      end
      OP_MFHI: o.result_value = hi_q;
      OP_MFLO: o.result_value = lo_q;
      OP_MTHI: hi_q = rs;
      OP_MTLO: lo_q = rs;
      OP_DMULT: begin
        prod = $signed({{64{rs[63]}}, rs}) * $signed({{64{rt[63]}}, rt});
        lo_q = prod[63:0];
        hi_q = prod[127:64];
      end
      OP_DMULTU: begin
        prod = {64'd0, rs} * {64'd0, rt};
        lo_q = prod[63:0];
        hi_q = prod[127:64];
      end
      OP_DDIV: begin
        if (rt == 64'd0) begin
          lo_q = '1;
          hi_q = rs;
        end else if (rs == 64'h8000_0000_0000_0000 && rt == '1) begin
          lo_q = rs;
          hi_q = '0;
        end else begin
          lo_q = $signed(rs) / $signed(rt);
          hi_q = $signed(rs) % $signed(rt);
        end
      end
      OP_DDIVU: begin
        if (rt == 64'd0) begin
          lo_q = '1;
          hi_q = rs;
        end else begin
          lo_q = rs / rt;
          hi_q = rs % rt;
        end
      end
      OP_J, OP_JAL: begin
        if (op == OP_JAL) o.result_value = link;
        o.next_counter = {w.program_counter[63:28], w.jump_target, 2'b00};
        o.redirect = 1'b1;
      end
      OP_JR, OP_JALR: begin
        if (op == OP_JALR) o.result_value = link;
        o.next_counter = rs;
        o.redirect = 1'b1;
      end
      OP_BEQ: cond = (rs == rt);
      OP_BNE: cond = (rs != rt);
      OP_BLEZ: cond = ($signed(rs) <= 0);
      OP_BGTZ: cond = ($signed(rs) > 0);
      OP_BLTZ: cond = rs[63];
      OP_BGEZ: cond = !rs[63];
      OP_BLTZAL: begin o.result_value = link; cond = rs[63]; end
      OP_BGEZAL: begin o.result_value = link; cond = !rs[63]; end
      OP_BEQL: begin likely = 1'b1; cond = (rs == rt); end
      OP_BNEL: begin likely = 1'b1; cond = (rs != rt); end
      OP_BLEZL: begin likely = 1'b1; cond = ($signed(rs) <= 0); end
      OP_BGTZL: begin likely = 1'b1; cond = ($signed(rs) > 0); end
      OP_BLTZL: begin likely = 1'b1; cond = rs[63]; end
      OP_BGEZL: begin likely = 1'b1; cond = !rs[63]; end
      OP_BLTZALL: begin o.result_value = link; likely = 1'b1; cond = rs[63]; end
      OP_BGEZALL: begin o.result_value = link; likely = 1'b1; cond = !rs[63]; end
      OP_TGE: o.trap_taken = !($signed(rs) < $signed(rt));
      OP_TGEU: o.trap_taken = rs >= rt;
      OP_TLT: o.trap_taken = $signed(rs) < $signed(rt);
      OP_TLTU: o.trap_taken = rs < rt;
      OP_TEQ: o.trap_taken = rs == rt;
      OP_TNE: o.trap_taken = rs != rt;
      OP_TGEI: o.trap_taken = !($signed(rs) < $signed(simm));
      OP_TGEIU: o.trap_taken = rs >= simm;
      OP_TLTI: o.trap_taken = $signed(rs) < $signed(simm);
      OP_TLTIU: o.trap_taken = rs < simm;
      OP_TEQI: o.trap_taken = rs == simm;
      OP_TNEI: o.trap_taken = rs != simm;
      OP_LWCZ, OP_SWCZ, OP_LDCZ, OP_SDCZ: begin
        o.result_value = rs + simm;
        o.memory_address = rs + simm;
      end
      OP_MTCZ, OP_MTC0: o.result_value = {32'd0, rt[31:0]};
      OP_MFCZ: o.result_value = {32'd0, w.coprocessor_value[31:0]};
      OP_MFC0: o.result_value = sext32(w.coprocessor_value);
      OP_DMTCZ, OP_DMTC0: o.result_value = rt;
      OP_DMFCZ, OP_DMFC0: o.result_value = w.coprocessor_value;
      default: begin
        if (w.kind <= OP_SDR) o.memory_address = rs + simm;
      end
    endcase
    if (cond > 0) begin
      o.redirect = 1'b1;
      o.next_counter = bt;
    end else if (cond == 0 && likely) begin
      o.annul_slot = 1'b1;
    end
    return o;
  endfunction

  // Offer one word, sometimes after a random idle burst, unless quiet.
  task automatic send_instr(input in_word_t w);
    int gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(exec_instr(w));
    kind_seen[w.kind] = 1'b1;
    n_sent++;
    // Valid stays high; an idle burst before the next word or a drain lowers it.
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = 64'h7FFF_FFFF_FFFF_FFFF;
      4: v = {32'd0, $urandom()};
      5: v = sext32({32'd0, $urandom()});
      6: v = {60'd0, 4'($urandom_range(0, 15))};
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  function automatic in_word_t rand_instr(input logic [6:0] kind);
    in_word_t w;
    w.kind              = kind;
    w.source_value      = rand64();
    w.second_value      = ($urandom_range(0, 4) == 0) ? w.source_value : rand64();
    w.immediate_field   = 16'($urandom());
    w.shift_amount      = 5'($urandom());
    w.jump_target       = 26'($urandom());
    w.program_counter   = {$urandom(), $urandom()};
    w.coprocessor_value = {$urandom(), $urandom()};
    return w;
  endfunction

  // Compare each result word with the oldest expectation.
  initial begin : check_results
    out_word_t exp_w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          n_errors++;
        end else begin
          exp_w = expected_q.pop_front();
          n_checked++;
          if (out_if.data.result_value !== exp_w.result_value) begin
            $error("result_value exp %h got %h", exp_w.result_value,
                   out_if.data.result_value);
            n_errors++;
          end
          if (out_if.data.memory_address !== exp_w.memory_address) begin
            $error("memory_address exp %h got %h", exp_w.memory_address,
                   out_if.data.memory_address);
            n_errors++;
          end
          if (out_if.data.next_counter !== exp_w.next_counter) begin
            $error("next_counter exp %h got %h", exp_w.next_counter,
                   out_if.data.next_counter);
            n_errors++;
          end
          if (out_if.data.redirect !== exp_w.redirect) begin
            $error("redirect exp %b got %b", exp_w.redirect, out_if.data.redirect);
            n_errors++;
          end
          if (out_if.data.annul_slot !== exp_w.annul_slot) begin
            $error("annul_slot exp %b got %b", exp_w.annul_slot,
                   out_if.data.annul_slot);
            n_errors++;
          end
          if (out_if.data.trap_taken !== exp_w.trap_taken) begin
            $error("trap_taken exp %b got %b", exp_w.trap_taken,
                   out_if.data.trap_taken);
            n_errors++;
          end
        end
      end
    end
  end

  // Drive ready: long hold-offs on request, random stall bursts otherwise.
  initial begin : drive_ready
    int burst;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
        out_if.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Drop valid and hold until every expected result has come.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed: field extremes and the special cases.
  task automatic test_directed();
    in_word_t w;
    // Divide by zero, word and doubleword, then read HI/LO back.
    w = rand_instr(OP_DIV);  w.second_value = 64'hFFFF_FFFF_0000_0000;
    send_instr(w);
    send_instr(rand_instr(OP_MFHI)); send_instr(rand_instr(OP_MFLO));
    w = rand_instr(OP_DDIVU); w.second_value = '0; send_instr(w);
    send_instr(rand_instr(OP_MFHI)); send_instr(rand_instr(OP_MFLO));
    // Signed divide overflow.
    w = rand_instr(OP_DDIV);
    w.source_value = 64'h8000_0000_0000_0000; w.second_value = '1;
    send_instr(w);
    send_instr(rand_instr(OP_MFLO)); send_instr(rand_instr(OP_MFHI));
    w = rand_instr(OP_DIV);
    w.source_value = 64'h8000_0000; w.second_value = '1;
    send_instr(w);
    send_instr(rand_instr(OP_MFLO));
    // Full-width products.
    w = rand_instr(OP_MULTU); w.source_value = '1; w.second_value = '1;
    send_instr(w); send_instr(rand_instr(OP_MFHI));
    w = rand_instr(OP_DMULT); w.source_value = '1; w.second_value = 64'h8000_0000_0000_0000;
    send_instr(w); send_instr(rand_instr(OP_MFHI));
    // Unsigned immediate traps against an extended immediate, and TNEI.
    w = rand_instr(OP_TGEIU); w.source_value = '1; w.immediate_field = 16'hFFFF;
    send_instr(w);
    w.kind = OP_TLTIU; w.source_value = 64'h7FFF; send_instr(w);
    w.kind = OP_TNEI; w.source_value = '1; send_instr(w);
    w.kind = OP_SLTI; send_instr(w);
    // Branch likely, both ways; shift extremes.
    w = rand_instr(OP_BEQL); w.second_value = w.source_value + 64'd1; send_instr(w);
    w.second_value = w.source_value; send_instr(w);
    w = rand_instr(OP_DSRA32); w.second_value = '1; w.shift_amount = 5'd31;
    send_instr(w);
    w.kind = OP_SLL; w.shift_amount = 5'd0; send_instr(w);
    w = rand_instr(OP_JAL); w.jump_target = '1; w.program_counter = '1; send_instr(w);
    w = rand_instr(OP_LWCZ); w.immediate_field = 16'h8000; send_instr(w);
    wait_drained();
  endtask

  // Every operation once, each operand random.
  task automatic test_every_op();
    for (int k = 0; k < 128; k++) send_instr(rand_instr(7'(k)));
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, behind a divide.
  task automatic test_backpressure();
    hold_cycles = 300;
    send_instr(rand_instr(OP_DDIVU));
    for (int i = 0; i < 12; i++) send_instr(rand_instr(7'($urandom_range(0, 127))));
    wait_drained();
  endtask

  // Random mix: mostly simple ops, with mul/div and HI/LO traffic.
  task automatic test_random(input int count);
    logic [6:0] k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) k = 7'($urandom_range(OP_MULT, OP_DDIVU));
      else k = 7'($urandom_range(0, 127));
      send_instr(rand_instr(k));
      if (i % 100 == 99) wait_drained();  // sender pause until all results came
    end
  endtask

  initial begin : run_tests
    int guard;
    int n_kinds;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    n_errors = 0; n_checked = 0; n_sent = 0;
    quiet_mode = 1'b0; hold_cycles = 0;
    hi_q = '0; lo_q = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // HI/LO reset value.
    send_instr(rand_instr(OP_MFHI));
    send_instr(rand_instr(OP_MFLO));
    test_directed();
    test_every_op();
    test_backpressure();
    test_random(180);
    quiet_mode = 1'b1;
    test_random(50);
    in_if.valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    n_kinds = 0;
    for (int k = 0; k < 128; k++) if (kind_seen[k]) n_kinds++;
    $display("Sent %0d words over %0d distinct operations, checked %0d results.",
             n_sent, n_kinds, n_checked);
    $display("Covered div by zero, divide overflow, wide products and stalls.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("** mips64_integer_execute_unit: PASSED **");
    end else begin
      $display("** mips64_integer_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
design/mxeu_pkg.sv
design/mxeu_if.sv
design/mxeu_front.sv
design/mxeu_muldiv.sv
design/mxeu_back.sv
design/mips64_integer_execute_unit.sv
tb/sv/testbench.sv
